/* sv/trve_pkg.sv */
// ----------------------------------------------------------------------------
// trve_pkg
// Shared types and constants for the touch release velocity estimator.
// ----------------------------------------------------------------------------
package trve_pkg;

   localparam logic [1:0] OP_DOWN = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_UP   = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam int DUR_BITS  = 16;
   localparam int WIN_BITS  = 16;
   localparam int VMAX_BITS = 20;
   localparam int VEL_BITS  = 21;
   localparam int TS_BITS   = 32;
   localparam int VEL_SCALE = 1000;

   localparam logic [0:0] CSR_WINDOW = 1'b0;
   localparam logic [0:0] CSR_VMAX   = 1'b1;

   // one classified event, front to back
   typedef struct packed {
      logic [1:0]          op;
      logic [31:0]         px;
      logic [31:0]         py;
      logic [TS_BITS-1:0]  ts;
   } event_type;

endpackage

/* sv/touch_release_velocity_estimator_unit.sv */
// ----------------------------------------------------------------------------
// touch_release_velocity_estimator_unit
// Fling velocity tracker: history of move records, velocity on release.
// ----------------------------------------------------------------------------
// down/move: handled in the back end; window drops read the memory.
// up: walks the history records per axis, then runs a radix-2 divide per axis.
// a 4-entry event queue decouples input from the back end.
// synchronous reset clears control state and loads the register defaults.
module touch_release_velocity_estimator_unit
   import trve_pkg::*;
#(
   parameter int HISTORY_DEPTH = 256,
   parameter int COORD_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[1:0], pos_x, pos_y, timestamp_ms
   input  logic [2+2*COORD_BITS+TS_BITS+((8-((2+2*COORD_BITS+TS_BITS)%8))%8)-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // velocity_x[20:0], velocity_y[41:21]
   output logic [47:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [19:0]  csr_wdata
);
   logic [WIN_BITS-1:0]  win_ff;
   logic [VMAX_BITS-1:0] vmax_ff;
   logic                 q_valid, q_ready;
   event_type            q_data;
   logic [VEL_BITS-1:0]  vx, vy;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 16'd128; vmax_ff <= 20'd8000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW: win_ff  <= csr_wdata[WIN_BITS-1:0];
            CSR_VMAX:   vmax_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   trve_front #(.COORD_BITS(COORD_BITS), .QDEPTH(4)) u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .in_op    (req_tdata[1:0]),
      .in_x     (req_tdata[2 +: COORD_BITS]),
      .in_y     (req_tdata[2+COORD_BITS +: COORD_BITS]),
      .in_ts    (req_tdata[2+2*COORD_BITS +: TS_BITS]),
      .q_valid, .q_ready, .q_data
   );

   trve_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset,
      .ev_valid (q_valid), .ev_ready (q_ready), .ev_data (q_data),
      .window_ms (win_ff), .max_velocity (vmax_ff),
      .out_valid (rsp_tvalid), .out_ready (rsp_tready),
      .out_vx (vx), .out_vy (vy)
   );

   assign rsp_tdata = {6'd0, vy, vx};
endmodule

/* sv/trve_front.sv */
// ----------------------------------------------------------------------------
// trve_front
// Input stage and event queue: drops unknown codes, buffers events.
// ----------------------------------------------------------------------------
module trve_front
   import trve_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int QDEPTH     = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            in_op,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   input  logic [TS_BITS-1:0]    in_ts,
   output logic                  q_valid,
   input  logic                  q_ready,
   output event_type             q_data
);
   localparam int AW = $clog2(QDEPTH);

   event_type       q_mem [QDEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;
   event_type       ev;

   assign in_ready = (cnt_ff != (AW+1)'(QDEPTH));
   assign push     = in_valid && in_ready && (in_op != OP_NONE);
   assign q_valid  = (cnt_ff != '0);
   assign pop      = q_valid && q_ready;
   assign q_data   = q_mem[rd_ff];

   always_comb begin
      ev.op = in_op;
      ev.px = 32'($signed(in_x));
      ev.py = 32'($signed(in_y));
      ev.ts = in_ts;
      wr_in  = push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) q_mem[wr_ff] <= ev;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(QDEPTH)) else $error("queue overfilled");
   a_pop_ne: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_cnt_upd: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
`endif
endmodule

/* sv/trve_back.sv */
// ----------------------------------------------------------------------------
// trve_back
// Back end: history memory, window upkeep, reversal walk, divide and clamp.
// ----------------------------------------------------------------------------
module trve_back
   import trve_pkg::*;
#(
   parameter int HISTORY_DEPTH = 256,
   parameter int COORD_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   output logic                  ev_ready,
   input  event_type             ev_data,
   input  logic [WIN_BITS-1:0]   window_ms,
   input  logic [VMAX_BITS-1:0]  max_velocity,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [VEL_BITS-1:0]   out_vx,
   output logic [VEL_BITS-1:0]   out_vy
);
   localparam int HA  = $clog2(HISTORY_DEPTH);
   localparam int DB  = COORD_BITS + 1;            // record delta width
   localparam int SB  = DB + HA + 1;               // running sum width
   localparam int TB  = DUR_BITS + HA + 1;         // running time width
   localparam int NB  = SB + 10;                   // scaled numerator width
   localparam int RW  = 2*DB + DUR_BITS;
   localparam int QB  = NB;

   localparam logic [3:0] S_IDLE = 4'd0, S_DROP_RD = 4'd1, S_DROP_WT = 4'd2,
      S_DROP = 4'd3, S_WALK_RD = 4'd4, S_WALK_WT = 4'd5, S_WALK = 4'd6,
      S_SCALE = 4'd7, S_DIV = 4'd8, S_CLAMP = 4'd9, S_OUT = 4'd10,
      S_PUSH2 = 4'd11;

   logic [RW-1:0]  mem [HISTORY_DEPTH];
   logic [RW-1:0]  rd_data_ff;
   logic [HA-1:0]  rd_addr;
   logic           rd_en;
   logic           wr_en;

   logic [3:0]     st_ff, st_in;
   logic           moving_ff;
   logic [COORD_BITS-1:0] lx_ff, ly_ff;
   logic [TS_BITS-1:0]    lt_ff;
   logic [TB-1:0]  wtot_ff;
   logic [HA:0]    cnt_ff;
   logic [HA-1:0]  newest_ff;

   // walk state
   logic           axis_ff;                        // 0 x, 1 y
   logic [HA:0]    idx_ff;
   logic           stop_ff;
   logic signed [SB-1:0] sum_ff;
   logic [TB-1:0]  tsum_ff;
   logic [NB-1:0]  num_ff;                         // magnitude of sum*1000
   logic           neg_ff;
   logic [QB-1:0]  quo_ff;
   logic [TB:0]    rem_ff;
   logic [$clog2(QB+1)-1:0] bit_ff;
   logic [VEL_BITS-1:0] vx_ff, vy_ff;

   // pending push record
   logic [RW-1:0]  new_rec;
   logic [DB-1:0]  ndx, ndy;
   logic [DUR_BITS-1:0] ndur;
   logic [TS_BITS-1:0]  gap;

   always_comb begin
      gap  = ev_data.ts - lt_ff;
      ndx  = DB'($signed(ev_data.px[COORD_BITS-1:0])) - DB'($signed(lx_ff));
      ndy  = DB'($signed(ev_data.py[COORD_BITS-1:0])) - DB'($signed(ly_ff));
      ndur = (gap > TS_BITS'(16'hFFFF)) ? 16'hFFFF : gap[DUR_BITS-1:0];
      new_rec = {ndur, ndy, ndx};
   end

   wire is_push = ev_valid && st_ff == S_IDLE && ev_data.op == OP_MOVE && moving_ff
                  && ev_data.ts > lt_ff;
   wire full    = cnt_ff == (HA+1)'(HISTORY_DEPTH);
   assign ev_ready = (st_ff == S_IDLE);
   assign wr_en    = is_push;

   wire [HA-1:0] oldest = newest_ff + HA'(1) - cnt_ff[HA-1:0];

   always_comb begin
      rd_en = 1'b0; rd_addr = oldest;
      if (st_ff == S_DROP_RD) begin
         rd_en = 1'b1;
      end else if (st_ff == S_WALK_RD) begin
         rd_en = 1'b1; rd_addr = newest_ff - idx_ff[HA-1:0];
      end else if (is_push && full) begin
         // read-first: the slot being overwritten still returns the oldest record
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[newest_ff + HA'(1)] <= new_rec;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // walk arithmetic
   logic signed [DB-1:0] rd_d;
   logic [DUR_BITS-1:0]  rd_dur;
   logic signed [SB-1:0] nsum;
   logic [SB-1:0]        mag_old, mag_new;
   logic [TB:0]          rem_sh;
   logic [TB-1:0]        wsum_after;
   always_comb begin
      rd_dur  = rd_data_ff[RW-1 -: DUR_BITS];
      rd_d    = axis_ff ? rd_data_ff[2*DB-1:DB] : rd_data_ff[DB-1:0];
      nsum    = sum_ff + SB'(rd_d);
      mag_old = sum_ff[SB-1] ? -sum_ff : sum_ff;
      mag_new = nsum[SB-1] ? -nsum : nsum;
      rem_sh  = {rem_ff[TB-1:0], num_ff[bit_ff - 1'b1]};
      wsum_after = wtot_ff + TB'(ndur);
   end

   logic [NB-1:0] qclamp;
   logic [VEL_BITS-1:0] vres;
   always_comb begin
      qclamp = (quo_ff > NB'(max_velocity)) ? NB'(max_velocity) : quo_ff;
      vres   = neg_ff ? -VEL_BITS'(qclamp) : VEL_BITS'(qclamp);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (ev_valid && ev_data.op == OP_UP) st_in = S_WALK_RD;
            else if (is_push && full) st_in = S_PUSH2;
            else if (is_push && wsum_after > TB'(window_ms)) st_in = S_DROP_RD;
         end
         S_PUSH2:   st_in = ((wtot_ff - TB'(rd_dur)) > TB'(window_ms)) ? S_DROP_RD : S_IDLE;
         S_DROP_RD: st_in = S_DROP_WT;
         S_DROP_WT: st_in = S_DROP;
         S_DROP:    st_in = S_IDLE;
         S_WALK_RD: st_in = (stop_ff || idx_ff == cnt_ff) ? S_SCALE : S_WALK_WT;
         S_WALK_WT: st_in = S_WALK;
         S_WALK:    st_in = S_WALK_RD;
         S_SCALE:   st_in = S_DIV;
         S_DIV:     st_in = (bit_ff == '0) ? S_CLAMP : S_DIV;
         S_CLAMP:   st_in = axis_ff ? S_OUT : S_WALK_RD;
         S_OUT:     st_in = out_ready ? S_IDLE : S_OUT;
         default:   st_in = S_IDLE;
      endcase
   end

   assign out_valid = (st_ff == S_OUT);
   assign out_vx = vx_ff;
   assign out_vy = vy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; moving_ff <= 1'b0; lx_ff <= '0; ly_ff <= '0; lt_ff <= '0;
         wtot_ff <= '0; cnt_ff <= '0; newest_ff <= '0;
         axis_ff <= 1'b0; idx_ff <= '0; stop_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            S_IDLE: if (ev_valid) begin
               if (ev_data.op == OP_DOWN) begin
                  lx_ff <= ev_data.px[COORD_BITS-1:0]; ly_ff <= ev_data.py[COORD_BITS-1:0];
                  lt_ff <= ev_data.ts; cnt_ff <= '0; wtot_ff <= '0;
               end else if (ev_data.op == OP_MOVE) begin
                  lt_ff <= ev_data.ts;
                  if (!moving_ff) begin
                     lx_ff <= ev_data.px[COORD_BITS-1:0];
                     ly_ff <= ev_data.py[COORD_BITS-1:0];
                     moving_ff <= 1'b1; wtot_ff <= '0; cnt_ff <= '0;
                  end else if (is_push) begin
                     lx_ff <= ev_data.px[COORD_BITS-1:0];
                     ly_ff <= ev_data.py[COORD_BITS-1:0];
                     newest_ff <= newest_ff + HA'(1);
                     wtot_ff <= wsum_after;
                     // when full the new record replaces the oldest, count stays
                     if (!full) cnt_ff <= cnt_ff + 1'b1;
                  end
               end else begin
                  moving_ff <= 1'b0; axis_ff <= 1'b0; idx_ff <= '0;
                  stop_ff <= 1'b0; sum_ff <= '0; tsum_ff <= '0;
               end
            end
            S_PUSH2: wtot_ff <= wtot_ff - TB'(rd_dur);
            S_DROP: begin
               wtot_ff <= wtot_ff - TB'(rd_dur);
               cnt_ff  <= cnt_ff - 1'b1;
            end
            S_WALK: begin
               if (mag_new < mag_old) stop_ff <= 1'b1;
               else begin
                  sum_ff <= nsum; tsum_ff <= tsum_ff + TB'(rd_dur);
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_SCALE: begin
               neg_ff <= sum_ff[SB-1];
               num_ff <= NB'(mag_old) * NB'(VEL_SCALE);
               quo_ff <= '0; rem_ff <= '0; bit_ff <= ($clog2(QB+1))'(QB);
            end
            S_DIV: if (bit_ff != '0) begin
               if (rem_sh >= {1'b0, tsum_ff}) begin
                  rem_ff <= rem_sh - {1'b0, tsum_ff};
                  quo_ff <= {quo_ff[QB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh; quo_ff <= {quo_ff[QB-2:0], 1'b0};
               end
               bit_ff <= bit_ff - 1'b1;
            end
            S_CLAMP: begin
               if (tsum_ff == '0) begin
                  if (axis_ff) vy_ff <= '0; else vx_ff <= '0;
               end else if (axis_ff) vy_ff <= vres;
               else vx_ff <= vres;
               axis_ff <= 1'b1; idx_ff <= '0; stop_ff <= 1'b0;
               sum_ff <= '0; tsum_ff <= '0;
            end
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (HA+1)'(HISTORY_DEPTH)) else $error("history overfilled");
   a_out: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_vx)) else $error("result lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !ev_ready) else $error("accept during result");
`endif
endmodule
